FILE: rtl/dhr_pkg.sv
package dhr_pkg;

    // Header layout: five bytes, checked in order.
    localparam logic [2:0] HP_D     = 3'd0;
    localparam logic [2:0] HP_H     = 3'd1;
    localparam logic [2:0] HP_KIND  = 3'd2;
    localparam logic [2:0] HP_WIDTH = 3'd3;
    localparam logic [2:0] HP_ROWS  = 3'd4;
    localparam logic [2:0] HDR_LEN  = 3'd5;

    localparam logic [7:0] HDR_CHAR_D   = 8'h44;
    localparam logic [7:0] HDR_CHAR_H   = 8'h48;
    localparam logic [7:0] HDR_KIND_RAW = 8'h52;
    localparam logic [7:0] HDR_KIND_RLE = 8'h58;
    localparam logic [7:0] HDR_WIDTH    = 8'd80;
    localparam logic [7:0] HDR_ROWS     = 8'd192;

    // A byte with both top bits set is a run count.
    localparam logic [1:0] RUN_TAG = 2'b11;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_file;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [7:0] row;
        logic [5:0] column;
        logic       to_aux;
        logic       image_done;
        logic       header_error;
        logic       last;
    } t_out_beat;

    // Placement of the byte at the current screen position.
    typedef struct packed {
        logic [7:0] row;
        logic [5:0] column;
        logic       to_aux;
        logic       image_done;
    } t_pos_info;

endpackage

FILE: rtl/dhr_pos.sv
module dhr_pos #(
    parameter int ROWS      = 192,
    parameter int ROW_BYTES = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_step,
    input  logic                i_compressed,
    output dhr_pkg::t_pos_info  o_info
);
    import dhr_pkg::*;

    localparam int BIR_W = $clog2(ROW_BYTES);
    localparam int HALF  = ROW_BYTES / 2;
    localparam int CW    = (BIR_W > 6) ? BIR_W : 6;

    logic [7:0]       r_row;
    logic [BIR_W-1:0] r_bir;
    logic [BIR_W:0]   bir_next;
    logic [BIR_W-1:0] col;
    logic [CW-1:0]    col_ext;
    logic             row_end;
    logic             last_row;
    logic             aux;

    assign bir_next = {1'b0, r_bir} + (BIR_W+1)'(1);
    assign row_end  = (bir_next == (BIR_W+1)'(ROW_BYTES));
    assign last_row = ({1'b0, r_row} + 9'd1) >= 9'(ROWS);

    // Run-length data interleaves the banks; raw data splits each row in half.
    always_comb begin
        if (i_compressed) begin
            aux = ~r_bir[0];
            col = r_bir >> 1;
        end else if (r_bir < BIR_W'(HALF)) begin
            aux = 1'b1;
            col = r_bir;
        end else begin
            aux = 1'b0;
            col = r_bir - BIR_W'(HALF);
        end
    end

    assign col_ext = CW'(col);

    assign o_info = '{
        row:        r_row,
        column:     col_ext[5:0],
        to_aux:     aux,
        image_done: row_end && last_row
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row <= '0;
            r_bir <= '0;
        end else if (i_step) begin
            if (row_end) begin
                r_bir <= '0;
                if (!last_row) begin
                    r_row <= r_row + 8'd1;
                end
            end else begin
                r_bir <= bir_next[BIR_W-1:0];
            end
        end
    end

endmodule

FILE: rtl/dhr_image_stream_decoder.sv
// Image stream decoder for double hi-res picture files.
//
// Input channel: one file byte per beat on i_in_beat, with start_of_file set
// on the first header byte to restart decoding. Output channel: one decoded
// screen byte per beat on o_out_beat, tagged with row, column and bank; the
// last beat caused by an input byte carries last.
// The five-byte header yields no beats, except a single error beat on the
// fifth byte of a bad header. Raw files give one beat per data byte; run-
// length files give one beat per literal byte, none for a count byte, and
// the whole run (up to 63 beats) on the byte that follows a count.
// The single beat of a literal, raw or bad-header byte is valid in the
// cycle after the byte is accepted; the first beat of a run is registered
// in the run state first and then in the output register. During a run the
// position unit places one byte per cycle unless the receiver stalls. The
// input is stalled while a run is being emitted and while the output
// register holds a beat.
// Reset clears the header check and the screen position; the first byte
// after reset is taken as header byte 0. When the receiver stalls, the
// output beat holds and the run in progress pauses.
module dhr_image_stream_decoder #(
    parameter int ROWS      = 192,
    parameter int ROW_BYTES = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dhr_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dhr_pkg::t_out_beat  o_out_beat
);
    import dhr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_hdr_idx, n_hdr_idx;
    logic       r_comp, n_comp;
    logic       r_failed, n_failed;
    logic       r_pend, n_pend;
    logic [5:0] r_count, n_count;
    logic       r_finished, n_finished;
    logic [5:0] r_left, n_left;
    logic [7:0] r_data, n_data;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out, n_out;

    logic       accept;
    logic       sof;
    logic [7:0] b;
    logic [2:0] e_hdr_idx;
    logic       e_failed;
    logic       hdr_ok;
    logic       fail_now;
    logic       out_free;
    logic       pos_step;
    t_pos_info  pos;

    dhr_pos #(
        .ROWS      (ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (accept && sof),
        .i_step       (pos_step),
        .i_compressed (r_comp),
        .o_info       (pos)
    );

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign sof         = i_in_beat.start_of_file;
    assign b           = i_in_beat.stream_byte;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Header state as seen by this byte; start of file restarts the check.
    assign e_hdr_idx = sof ? HP_D : r_hdr_idx;
    assign e_failed  = sof ? 1'b0 : r_failed;

    always_comb begin
        unique case (e_hdr_idx)
            HP_D:     hdr_ok = (b == HDR_CHAR_D);
            HP_H:     hdr_ok = (b == HDR_CHAR_H);
            HP_KIND:  hdr_ok = (b == HDR_KIND_RAW) || (b == HDR_KIND_RLE);
            HP_WIDTH: hdr_ok = (b == HDR_WIDTH);
            default:  hdr_ok = (b == HDR_ROWS);
        endcase
    end

    assign fail_now = e_failed || !hdr_ok;

    always_comb begin
        n_state     = r_state;
        n_hdr_idx   = r_hdr_idx;
        n_comp      = r_comp;
        n_failed    = r_failed;
        n_pend      = r_pend;
        n_count     = r_count;
        n_finished  = r_finished;
        n_left      = r_left;
        n_data      = r_data;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        pos_step    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (sof) begin
                        n_hdr_idx  = HP_D;
                        n_comp     = 1'b0;
                        n_failed   = 1'b0;
                        n_pend     = 1'b0;
                        n_count    = '0;
                        n_finished = 1'b0;
                    end
                    if (e_hdr_idx < HDR_LEN) begin
                        n_hdr_idx = e_hdr_idx + 3'd1;
                        n_failed  = fail_now;
                        if (e_hdr_idx == HP_KIND) begin
                            n_comp = (b == HDR_KIND_RLE);
                        end
                        if (e_hdr_idx == HP_ROWS && fail_now) begin
                            n_out_valid = 1'b1;
                            n_out = '{pixel_byte: '0, row: '0, column: '0,
                                      to_aux: 1'b0, image_done: 1'b0,
                                      header_error: 1'b1, last: 1'b1};
                        end
                    end else if (!r_failed && !r_finished) begin
                        if (r_comp && r_pend) begin
                            // The byte after a count: start the run if any.
                            n_pend  = 1'b0;
                            n_count = '0;
                            if (r_count != '0) begin
                                n_state = S_RUN;
                                n_left  = r_count;
                                n_data  = b;
                            end
                        end else if (r_comp && b[7:6] == RUN_TAG) begin
                            n_pend  = 1'b1;
                            n_count = b[5:0];
                        end else begin
                            pos_step    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out = '{pixel_byte: b, row: pos.row,
                                      column: pos.column, to_aux: pos.to_aux,
                                      image_done: pos.image_done,
                                      header_error: 1'b0, last: 1'b1};
                            if (pos.image_done) begin
                                n_finished = 1'b1;
                            end
                        end
                    end
                end
            end
            S_RUN: begin
                // One repeated byte per cycle while the output is not stalled; a run is cut at the image end.
                if (out_free) begin
                    pos_step    = 1'b1;
                    n_out_valid = 1'b1;
                    n_left      = r_left - 6'd1;
                    n_out = '{pixel_byte: r_data, row: pos.row,
                              column: pos.column, to_aux: pos.to_aux,
                              image_done: pos.image_done, header_error: 1'b0,
                              last: (r_left == 6'd1) || pos.image_done};
                    if (pos.image_done) begin
                        n_finished = 1'b1;
                    end
                    if ((r_left == 6'd1) || pos.image_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hdr_idx   <= HP_D;
            r_comp      <= 1'b0;
            r_failed    <= 1'b0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_finished  <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hdr_idx   <= n_hdr_idx;
            r_comp      <= n_comp;
            r_failed    <= n_failed;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_finished  <= n_finished;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_data <= n_data;
        r_out  <= n_out;
    end

    // A run in progress always has bytes left to emit.
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_left != 6'd0))
        else $error("run state with no bytes left");

    // An error beat on the output belongs to a failed header.
    a_err_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.header_error) |-> r_failed)
        else $error("header error beat without failed header");

    // The final image beat leaves the decoder finished and idle.
    a_done_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.image_done) |-> (r_finished && r_state == S_IDLE))
        else $error("image done beat while decoder not finished");

    // A pending count only exists for run-length files.
    a_pend_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_comp)
        else $error("pending run count in a raw file");

endmodule

FILE: tb/sv/dhr_decoder_checker.sv
`timescale 1ns / 100ps

module dhr_decoder_checker #(
    parameter int ROWS      = 192,
    parameter int ROW_BYTES = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  dhr_pkg::t_in_beat   i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  dhr_pkg::t_out_beat  i_out_beat,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_beats_checked,
    output int                  o_images_done,
    output int                  o_header_errors
);
    import dhr_pkg::*;

    localparam int HALF_ROW = ROW_BYTES / 2;

    // Decoder state as the file stream leaves it.
    logic [2:0]  hdr_pos;
    bit          rle_file;
    bit          hdr_bad;
    bit          count_pending;
    bit          image_full;
    int unsigned run_len;
    int unsigned cur_row;
    int unsigned row_pos;

    t_out_beat screen_beats_due[$];

    int fail_total;
    int beats_checked;
    int images_done;
    int header_errors;

    task automatic clear_decoder();
        hdr_pos       = '0;
        rle_file      = 1'b0;
        hdr_bad       = 1'b0;
        count_pending = 1'b0;
        image_full    = 1'b0;
        run_len       = 0;
        cur_row       = 0;
        row_pos       = 0;
    endtask

    function automatic string beat_text(input t_out_beat b);
        return $sformatf("byte %h row %0d col %0d aux %b done %b err %b last %b",
                         b.pixel_byte, b.row, b.column, b.to_aux, b.image_done,
                         b.header_error, b.last);
    endfunction

    // Places one decoded byte at the current screen position and queues its beat.
    task automatic place_byte(input logic [7:0] value);
        t_out_beat   beat;
        int unsigned col;
        beat = '0;
        beat.pixel_byte = value;
        beat.row = cur_row[7:0];
        if (rle_file) begin
            beat.to_aux = (row_pos[0] == 1'b0);
            col = row_pos >> 1;
        end else if (row_pos < HALF_ROW) begin
            beat.to_aux = 1'b1;
            col = row_pos;
        end else begin
            beat.to_aux = 1'b0;
            col = row_pos - HALF_ROW;
        end
        beat.column = col[5:0];
        row_pos++;
        if (row_pos >= ROW_BYTES) begin
            row_pos = 0;
            if (cur_row + 1 >= ROWS) begin
                image_full = 1'b1;
                beat.image_done = 1'b1;
            end else begin
                cur_row = (cur_row + 1) & 8'hFF;
            end
        end
        screen_beats_due.push_back(beat);
    endtask

    task automatic decode_file_byte(input t_in_beat b);
        bit          ok;
        int unsigned n;
        int unsigned k;
        t_out_beat   tail;
        n = 0;
        if (b.start_of_file) begin
            clear_decoder();
        end
        if (hdr_pos < HDR_LEN) begin
            case (hdr_pos)
                HP_D: begin
                    ok = (b.stream_byte == HDR_CHAR_D);
                end
                HP_H: begin
                    ok = (b.stream_byte == HDR_CHAR_H);
                end
                HP_KIND: begin
                    ok = (b.stream_byte == HDR_KIND_RAW) || (b.stream_byte == HDR_KIND_RLE);
                    rle_file = (b.stream_byte == HDR_KIND_RLE);
                end
                HP_WIDTH: begin
                    ok = (b.stream_byte == HDR_WIDTH);
                end
                default: begin
                    ok = (b.stream_byte == HDR_ROWS);
                end
            endcase
            if (!ok) begin
                hdr_bad = 1'b1;
            end
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == HDR_LEN && hdr_bad) begin
                tail = '0;
                tail.header_error = 1'b1;
                tail.last = 1'b1;
                screen_beats_due.push_back(tail);
            end
        end else if (!hdr_bad && !image_full) begin
            if (!rle_file) begin
                place_byte(b.stream_byte);
                n = 1;
            end else if (count_pending) begin
                count_pending = 1'b0;
                for (k = 0; k < run_len && !image_full; k++) begin
                    place_byte(b.stream_byte);
                    n++;
                end
                run_len = 0;
            end else if (b.stream_byte[7:6] == RUN_TAG) begin
                count_pending = 1'b1;
                run_len = 32'(b.stream_byte[5:0]);
            end else begin
                place_byte(b.stream_byte);
                n = 1;
            end
            if (n > 0) begin
                tail = screen_beats_due.pop_back();
                tail.last = 1'b1;
                screen_beats_due.push_back(tail);
            end
        end
    endtask

    task automatic note_failure(input string what, input string wanted, input t_out_beat got);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s", $time, what);
            $display("    expected %s", wanted);
            $display("    got      %s", beat_text(got));
        end
    endtask

    task automatic check_beat(input t_out_beat got);
        t_out_beat want;
        bit        bad;
        beats_checked++;
        if (got.image_done === 1'b1) begin
            images_done++;
        end
        if (got.header_error === 1'b1) begin
            header_errors++;
        end
        if (screen_beats_due.size() == 0) begin
            note_failure("output beat with nothing outstanding", "no beat", got);
        end else begin
            want = screen_beats_due.pop_front();
            bad = (got.pixel_byte !== want.pixel_byte) || (got.row !== want.row)
               || (got.column !== want.column) || (got.to_aux !== want.to_aux)
               || (got.image_done !== want.image_done)
               || (got.header_error !== want.header_error) || (got.last !== want.last);
            if (bad) begin
                note_failure("output beat mismatch", beat_text(want), got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            screen_beats_due.delete();
            fail_total    = 0;
            beats_checked = 0;
            images_done   = 0;
            header_errors = 0;
        end else begin
            // Results are registered after their byte, so the output side goes first.
            if (i_out_valid && !i_out_stall) begin
                check_beat(i_out_beat);
            end
            if (i_in_valid && !i_in_stall) begin
                decode_file_byte(i_in_beat);
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= screen_beats_due.size();
        o_beats_checked <= beats_checked;
        o_images_done   <= images_done;
        o_header_errors <= header_errors;
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dhr_pkg::*;

    localparam int ROWS        = 192;
    localparam int ROW_BYTES   = 80;
    localparam int IMAGE_BYTES = ROWS * ROW_BYTES;

    // Budget of decoded file bytes per idling phase, not counting full images.
    localparam int PHASE_ITEMS = 125;

    // Length of the one long receiver hold-off that makes the block back up.
    localparam int HOLD_CYCLES = 400;

    // A 63-byte run plus pipeline slack is the longest the block can still be busy.
    localparam int DRAIN_CYCLES = 128;

    // The slowest correct run is two full images (about 31k beats) plus roughly
    // 500 small-file bytes, with the worst phase stalling 85 percent of cycles.
    // This limit leaves a wide margin even if every byte sent started a full
    // 63-beat run under the heaviest stalling.
    localparam int CYCLE_LIMIT = 5000000;

    // Largest byte that still stands for itself in a run-length file.
    localparam logic [7:0] LITERAL_MAX = 8'hBF;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_beat   in_beat = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_beat  out_beat;

    int fail_count;
    int pending;
    int beats_checked;
    int images_done;
    int header_errors;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // The stimulus bumps hold_trigger; the receiver process notices the change
    // and counts out its own hold-off.
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    int unsigned cycles = 0;
    int phase_items = 0;
    int items_total = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dhr_image_stream_decoder #(
        .ROWS      (ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    // The checker sees every handshake on both channels, runs its own decoder
    // and compares each output beat with the oldest one it predicted.
    dhr_decoder_checker #(
        .ROWS      (ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) beat_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_beat       (in_beat),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_beat      (out_beat),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked),
        .o_images_done   (images_done),
        .o_header_errors (header_errors)
    );

    // Receiver side. A pending hold-off request wins over random stalls, and
    // while it counts down the output stays stalled no matter the phase.
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog. A hang anywhere in the flow ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d beats outstanding.", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] count_byte(input logic [5:0] n);
        return {RUN_TAG, n};
    endfunction

    // Offers one file byte and waits until it is taken. The sender may idle
    // first; once valid is up the payload holds until the stall drops.
    // Trailing bytes after a bad header and full-image bytes are sent with
    // tally low so that they do not count against the phase budget.
    task automatic send_byte(input logic [7:0] value, input logic sof, input bit tally);
        t_in_beat beat;
        beat.stream_byte   = value;
        beat.start_of_file = sof;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_total++;
        if (tally) begin
            phase_items++;
        end
    endtask

    task automatic send_header(input bit rle);
        send_byte(HDR_CHAR_D, 1'b1, 1'b1);
        send_byte(HDR_CHAR_H, 1'b0, 1'b1);
        send_byte(rle ? HDR_KIND_RLE : HDR_KIND_RAW, 1'b0, 1'b1);
        send_byte(HDR_WIDTH, 1'b0, 1'b1);
        send_byte(HDR_ROWS, 1'b0, 1'b1);
    endtask

    // A header with one byte swapped for a wrong value, then a few trailing
    // bytes that the decoder must drop until the next start of file.
    task automatic send_bad_header();
        logic [7:0]  hdr [0:4];
        logic [7:0]  junk;
        int unsigned bad_pos;
        int          k;
        hdr[0] = HDR_CHAR_D;
        hdr[1] = HDR_CHAR_H;
        hdr[2] = $urandom_range(0, 1) ? HDR_KIND_RLE : HDR_KIND_RAW;
        hdr[3] = HDR_WIDTH;
        hdr[4] = HDR_ROWS;
        bad_pos = $urandom_range(0, 4);
        do begin
            junk = 8'($urandom_range(0, 255));
        end while (junk == hdr[bad_pos] || (bad_pos == HP_KIND
                   && (junk == HDR_KIND_RLE || junk == HDR_KIND_RAW)));
        hdr[bad_pos] = junk;
        for (k = 0; k < 5; k++) begin
            send_byte(hdr[k], k == 0, 1'b1);
        end
        repeat ($urandom_range(1, 4)) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
    endtask

    // Run-length data: mostly literals and complete runs of any length,
    // now and then a bare count whose data byte is whatever comes next.
    task automatic send_rle_body(input int n);
        int k;
        int choice;
        for (k = 0; k < n; k++) begin
            choice = $urandom_range(0, 9);
            if (choice < 6) begin
                send_byte(8'($urandom_range(0, LITERAL_MAX)), 1'b0, 1'b1);
            end else if (choice < 9) begin
                send_byte(count_byte(6'($urandom_range(0, 63))), 1'b0, 1'b1);
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end else begin
                send_byte(count_byte(6'($urandom_range(0, 63))), 1'b0, 1'b1);
            end
        end
    endtask

    task automatic send_raw_body(input int n);
        repeat (n) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Random bytes with an occasional start of file, which restarts the
    // header check on a byte that is almost never a valid header.
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    // A complete run-length image, built mostly from long runs so that it
    // needs only a few hundred bytes. With exact_end the last run lands on
    // the final screen byte; otherwise a full 63-byte run overshoots the end
    // and must be cut short. A few bytes follow that the decoder must ignore.
    task automatic send_full_image(input bit exact_end);
        int remaining;
        int run;
        send_header(1'b1);
        remaining = IMAGE_BYTES;
        while (remaining > 62) begin
            if ($urandom_range(0, 7) == 0) begin
                send_byte(8'($urandom_range(0, LITERAL_MAX)), 1'b0, 1'b0);
                remaining--;
            end else begin
                run = $urandom_range(32, 63);
                if (run > remaining - 1) begin
                    run = remaining - 1;
                end
                send_byte(count_byte(6'(run)), 1'b0, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                remaining -= run;
            end
        end
        if (exact_end && remaining == 1) begin
            send_byte(8'($urandom_range(0, LITERAL_MAX)), 1'b0, 1'b0);
        end else begin
            send_byte(count_byte(6'(exact_end ? remaining : 63)), 1'b0, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        repeat (4) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
    endtask

    initial begin
        int phase;
        int pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first file comes straight after reset without a
        // start-of-file mark, so the decoder has to take it as header byte 0.
        send_byte(HDR_CHAR_D, 1'b0, 1'b1);
        send_byte(HDR_CHAR_H, 1'b0, 1'b1);
        send_byte(HDR_KIND_RLE, 1'b0, 1'b1);
        send_byte(HDR_WIDTH, 1'b0, 1'b1);
        send_byte(HDR_ROWS, 1'b0, 1'b1);
        // Smallest and largest literals.
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(LITERAL_MAX, 1'b0, 1'b1);
        // A zero count swallows its data byte and gives nothing.
        send_byte(count_byte(6'd0), 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        // Shortest and longest runs; both stay within the first row.
        send_byte(count_byte(6'd1), 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(count_byte(6'd63), 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        // Raw file with the extreme byte values.
        send_header(1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        // Bad kind byte, then a byte that must be ignored.
        send_byte(HDR_CHAR_D, 1'b1, 1'b1);
        send_byte(HDR_CHAR_H, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(HDR_WIDTH, 1'b0, 1'b1);
        send_byte(HDR_ROWS, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);

        // Random part in four idling phases: none, sender idle most of the
        // time, receiver stalled most of the time, and both now and then.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    // Long hold-off while the sender keeps offering bytes,
                    // so the block fills up and stalls its input.
                    hold_trigger <= hold_trigger + 1;
                end
                1: begin
                    idle_pct = 85;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 85;
                end
                default: begin
                    idle_pct = 22;
                    stall_pct <= 22;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    send_header(1'b1);
                    send_rle_body($urandom_range(1, 30));
                end else if (pick < 7) begin
                    send_header(1'b0);
                    send_raw_body($urandom_range(1, 120));
                end else if (pick < 9) begin
                    send_bad_header();
                end else begin
                    send_noise();
                end
            end
            if (phase == 0) begin
                send_full_image(1'b0);
            end else if (phase == 3) begin
                send_full_image(1'b1);
            end
        end
        in_valid <= 1'b0;

        // Wait for the last predicted beat, then give the block time to show
        // any beat that nobody predicted.
        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d file bytes (raw, run-length, bad-header and noise files) %s",
                 items_total, "under four idling phases and one long output hold-off.");
        $display("Checked %0d output beats: %0d full images and %0d header errors.",
                 beats_checked, images_done, header_errors);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d output beats failed the check.", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/dhr_pkg.sv
rtl/dhr_pos.sv
rtl/dhr_image_stream_decoder.sv
tb/sv/dhr_decoder_checker.sv
tb/sv/testbench.sv
